>>> hw/rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflect/refract package.
// Widths shared by the unit and its divider and square-root pipelines, and the
// fixed-point constants, record types and rounding helpers of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frr_pkg;

   localparam int FRAC      = 16;
   localparam int VEC_W     = FRAC + 2;
   localparam int IOR_W     = FRAC + 3;
   localparam int WGT_W     = FRAC + 1;
   localparam int WSUM_W    = WGT_W + 1;

   localparam int RAT_W     = FRAC + 4;
   localparam int NUM_W     = 2 * FRAC + 4;
   localparam int DIV_STEPS = RAT_W;
   localparam int ROOT_W    = FRAC + 1;
   localparam int SQ_W      = 2 * ROOT_W;

   localparam int PROD_W    = 2 * VEC_W;
   localparam int DOT_W     = FRAC + 5;
   localparam int DN_W      = DOT_W + VEC_W;
   localparam int X_W       = FRAC + 2;
   localparam int X2_W      = FRAC + 3;
   localparam int X4_W      = FRAC + 5;
   localparam int X5_W      = FRAC + 6;
   localparam int R2_W      = FRAC + 7;
   localparam int S2_W      = FRAC + 8;
   localparam int RC_W      = FRAC + 5;
   localparam int RD_W      = FRAC + 6;
   localparam int K_W       = FRAC + 6;
   localparam int KN_W      = FRAC + 7;

   localparam int HIT_DEPTH = 6;
   localparam int SIDE_DLY  = DIV_STEPS - 5;
   localparam int SIDE2_DLY = ROOT_W;
   localparam int LATENCY   = 11 + SIDE_DLY + SIDE2_DLY;

   typedef logic signed [47:0]       wide_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic [IOR_W-1:0]         ior_type;
   typedef logic [WGT_W-1:0]         wgt_type;
   typedef logic signed [RD_W-1:0]   rd_type;

   localparam wide_type ONE_W     = wide_type'(1) <<< FRAC;
   localparam wide_type HALF_W    = wide_type'(1) <<< (FRAC - 1);
   localparam wide_type VEC_MAX_W = (wide_type'(1) <<< (VEC_W - 1)) - wide_type'(1);
   localparam wide_type VEC_MIN_W = -(wide_type'(1) <<< (VEC_W - 1));
   localparam ior_type  IOR_ONE   = ior_type'(1) << FRAC;
   localparam wgt_type  ONE_WGT   = wgt_type'(1) << FRAC;

   typedef struct packed {
      logic             eq;
      vec_type [2:0]    dv;
      vec_type [2:0]    nv;
   } hit_type;

   typedef struct packed {
      logic             eq;
      vec_type [2:0]    dv;
      vec_type [2:0]    nv;
      vec_type [2:0]    mir;
      vec_type          cosv;
      wgt_type          omc;
      logic [X5_W-1:0]  x5;
   } side_type;

   typedef struct packed {
      logic                   eq;
      logic                   zb;
      logic                   tir;
      wgt_type                wgt;
      logic signed [RC_W-1:0] rc;
      rd_type [2:0]           rd;
      vec_type [2:0]          dv;
      vec_type [2:0]          nv;
      vec_type [2:0]          mir;
   } side2_type;

   // Drops FRAC fraction bits, rounding half away from zero.
   function automatic wide_type rnd_f(input wide_type v);
      wide_type mag;
      mag = ((v < 0) ? -v : v) + HALF_W;
      mag = mag >>> FRAC;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic vec_type sat_vec(input wide_type v);
      wide_type c;
      if (v > VEC_MAX_W) begin
         c = VEC_MAX_W;
      end else if (v < VEC_MIN_W) begin
         c = VEC_MIN_W;
      end else begin
         c = v;
      end
      return vec_type'(c);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/frr_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider.
// One quotient bit per stage; the quotient is known to fit in RAT_W bits, so
// the upper numerator bits seed the remainder directly.
// ----------------------------------------------------------------------------
`default_nettype none

module frr_div import frr_pkg::*; (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [RAT_W-1:0] den,
   output logic [RAT_W-1:0] quo
);

   logic [RAT_W-1:0] rem_ff [DIV_STEPS];
   logic [RAT_W-1:0] low_ff [DIV_STEPS];
   logic [RAT_W-1:0] den_ff [DIV_STEPS];
   logic [RAT_W-1:0] quo_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [RAT_W-1:0] rem_src;
      logic [RAT_W-1:0] low_src;
      logic [RAT_W-1:0] den_src;
      logic [RAT_W-1:0] quo_src;
      logic [RAT_W:0]   trial;
      logic [RAT_W-1:0] rem_in;
      logic [RAT_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_src = RAT_W'(num[NUM_W-1:RAT_W]);
         assign low_src = num[RAT_W-1:0];
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign low_src = low_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end

      always_comb begin
         trial = {rem_src, low_src[RAT_W-1]};
         if (trial >= {1'b0, den_src}) begin
            rem_in = RAT_W'(trial - {1'b0, den_src});
            quo_in = {quo_src[RAT_W-2:0], 1'b1};
         end else begin
            rem_in = RAT_W'(trial);
            quo_in = {quo_src[RAT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= rem_in;
            low_ff[i] <= {low_src[RAT_W-2:0], 1'b0};
            den_ff[i] <= den_src;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> hw/rtl/frr_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root.
// Digit-by-digit floor square root, one result bit and two radicand bits per
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module frr_sqrt import frr_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [SQ_W-1:0]   value,
   output logic [ROOT_W-1:0] root
);

   logic [ROOT_W:0]   rem_ff  [ROOT_W];
   logic [SQ_W-1:0]   low_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [ROOT_W:0]   rem_src;
      logic [SQ_W-1:0]   low_src;
      logic [ROOT_W-1:0] root_src;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W+2:0] test;
      logic [ROOT_W:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign low_src  = value;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign low_src  = low_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      always_comb begin
         trial = {rem_src, low_src[SQ_W-1:SQ_W-2]};
         test  = {1'b0, root_src, 2'b01};
         if (trial >= test) begin
            rem_in  = (ROOT_W+1)'(trial - test);
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (ROOT_W+1)'(trial);
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            low_ff[i]  <= {low_src[SQ_W-3:0], 2'b00};
            root_ff[i] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/fresnel_reflect_refract.sv
// ----------------------------------------------------------------------------
// Fresnel reflect/refract unit: mirror and Snell directions, Schlick weight.
// Latency is 43 register stages from the req transfer to rsp_valid.
// Throughput is one transfer per cycle; a stalled result holds the whole pipeline.
// Latency is set by the bit-per-stage index dividers and the square-root pipeline.
// Reset clears only the valid bits; datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fresnel_reflect_refract import frr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  vec_type req_dir_x,
   input  vec_type req_dir_y,
   input  vec_type req_dir_z,
   input  vec_type req_norm_x,
   input  vec_type req_norm_y,
   input  vec_type req_norm_z,
   input  ior_type req_ior_in,
   input  ior_type req_ior_out,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output vec_type rsp_mirror_x,
   output vec_type rsp_mirror_y,
   output vec_type rsp_mirror_z,
   output vec_type rsp_bent_x,
   output vec_type rsp_bent_y,
   output vec_type rsp_bent_z,
   output wgt_type rsp_mirror_weight,
   output wgt_type rsp_pass_weight,
   output logic    rsp_full_reflection
);

   logic                    adv;
   logic [LATENCY-1:0]      vld_ff;

   ior_type                 n1_in;
   ior_type                 n2_in;
   hit_type                 hit_in;
   ior_type                 n1_ff;
   ior_type                 n2_ff;
   hit_type                 hit_ff [HIT_DEPTH];

   ior_type                 diff;
   logic [RAT_W-1:0]        sum;
   logic [NUM_W-1:0]        num_r;
   logic [NUM_W-1:0]        num_q;
   logic [RAT_W-1:0]        ratio;
   logic [RAT_W-1:0]        qv;

   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [DOT_W-1:0]  dot_ff;
   logic signed [DN_W-1:0]   dn_ff [3];
   wide_type                 negd;
   vec_type                  cos_in;
   vec_type                  cos_ff;
   vec_type                  cos5_ff;
   vec_type                  cos6_ff;
   vec_type                  mir5_ff [3];
   vec_type                  mir6_ff [3];
   wide_type                 x_in;
   logic [X_W-1:0]           x5_ff;
   logic [X_W-1:0]           x6_ff;
   logic [X2_W-1:0]          x2_ff;
   logic [X4_W-1:0]          x4_ff;
   wgt_type                  omc5_ff;
   wgt_type                  omc6_ff;

   side_type                 side_in;
   side_type                 side_ff [SIDE_DLY];
   side_type                 side_out;

   logic [R2_W-1:0]          rat_r2_ff;
   wgt_type                  rat_r0_ff;
   logic signed [RC_W-1:0]   rat_rc_ff;
   rd_type                   rat_rd_ff [3];
   side_type                 rat_side_ff;

   logic [S2_W-1:0]          sq_s2_ff;
   wgt_type                  sq_wgt_in;
   wgt_type                  sq_wgt_ff;
   logic signed [RC_W-1:0]   sq_rc_ff;
   rd_type                   sq_rd_ff [3];
   side_type                 sq_side_ff;
   wide_type                 wsum;
   logic [SQ_W-1:0]          sq_v;

   side2_type                side2_in;
   side2_type                side2_ff [SIDE2_DLY];
   side2_type                side2_out;
   logic [ROOT_W-1:0]        root;

   logic signed [K_W-1:0]    k_ff;
   side2_type                k_side_ff;
   logic signed [KN_W-1:0]   kn_ff [3];
   side2_type                kn_side_ff;

   vec_type                  out_mir_ff  [3];
   vec_type                  out_bent_ff [3];
   wgt_type                  out_wgt_ff;
   wgt_type                  out_pass_ff;
   logic                     out_tir_ff;

   // The whole pipeline holds while a finished result waits to be taken.
   assign adv       = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   always_comb begin
      n1_in     = (req_ior_in < IOR_ONE) ? IOR_ONE : req_ior_in;
      n2_in     = (req_ior_out < IOR_ONE) ? IOR_ONE : req_ior_out;
      hit_in.eq = (n1_in == n2_in);
      hit_in.dv = {req_dir_z, req_dir_y, req_dir_x};
      hit_in.nv = {req_norm_z, req_norm_y, req_norm_x};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff     <= n1_in;
         n2_ff     <= n2_in;
         hit_ff[0] <= hit_in;
         for (int s = 1; s < HIT_DEPTH; s++) begin
            hit_ff[s] <= hit_ff[s-1];
         end
      end
   end

   always_comb begin
      diff  = (n1_ff > n2_ff) ? (n1_ff - n2_ff) : (n2_ff - n1_ff);
      sum   = RAT_W'(n1_ff) + RAT_W'(n2_ff);
      num_r = (NUM_W'(n1_ff) << FRAC) + NUM_W'(n2_ff >> 1);
      num_q = (NUM_W'(diff) << FRAC) + NUM_W'(sum >> 1);
   end

   frr_div u_div_ratio (
      .clock  (clock),
      .enable (adv),
      .num    (num_r),
      .den    (RAT_W'(n2_ff)),
      .quo    (ratio)
   );

   frr_div u_div_r0 (
      .clock  (clock),
      .enable (adv),
      .num    (num_q),
      .den    (sum),
      .quo    (qv)
   );

   always_comb begin
      negd = -wide_type'(dot_ff);
      if (negd > ONE_W) begin
         cos_in = vec_type'(ONE_W);
      end else if (negd < -ONE_W) begin
         cos_in = vec_type'(-ONE_W);
      end else begin
         cos_in = vec_type'(negd);
      end
      x_in = ONE_W - wide_type'(cos_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= PROD_W'(wide_type'(hit_ff[0].dv[i]) * wide_type'(hit_ff[0].nv[i]));
            dn_ff[i]   <= DN_W'(wide_type'(dot_ff) * wide_type'(hit_ff[2].nv[i]));
            mir5_ff[i] <= sat_vec(wide_type'(hit_ff[3].dv[i])
                                  - rnd_f(wide_type'(dn_ff[i]) <<< 1));
            mir6_ff[i] <= mir5_ff[i];
         end
         dot_ff  <= DOT_W'(rnd_f(wide_type'(prod_ff[0]) + wide_type'(prod_ff[1])
                                 + wide_type'(prod_ff[2])));
         cos_ff  <= cos_in;
         cos5_ff <= cos_ff;
         cos6_ff <= cos5_ff;
         omc5_ff <= wgt_type'(ONE_W - rnd_f(wide_type'(cos_ff) * wide_type'(cos_ff)));
         omc6_ff <= omc5_ff;
         x5_ff   <= X_W'(x_in);
         x6_ff   <= x5_ff;
         x2_ff   <= X2_W'(rnd_f(x_in * x_in));
         x4_ff   <= X4_W'(rnd_f(wide_type'(x2_ff) * wide_type'(x2_ff)));
      end
   end

   always_comb begin
      side_in.eq   = hit_ff[5].eq;
      side_in.dv   = hit_ff[5].dv;
      side_in.nv   = hit_ff[5].nv;
      side_in.mir  = {mir6_ff[2], mir6_ff[1], mir6_ff[0]};
      side_in.cosv = cos6_ff;
      side_in.omc  = omc6_ff;
      side_in.x5   = X5_W'(rnd_f(wide_type'(x4_ff) * wide_type'(x6_ff)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < SIDE_DLY; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign side_out = side_ff[SIDE_DLY-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rat_r2_ff   <= R2_W'(rnd_f(wide_type'(ratio) * wide_type'(ratio)));
         rat_r0_ff   <= WGT_W'(rnd_f(wide_type'(qv) * wide_type'(qv)));
         rat_rc_ff   <= RC_W'(rnd_f(wide_type'(ratio) * wide_type'(side_out.cosv)));
         for (int i = 0; i < 3; i++) begin
            rat_rd_ff[i] <= RD_W'(rnd_f(wide_type'(ratio) * wide_type'(side_out.dv[i])));
            sq_rd_ff[i]  <= rat_rd_ff[i];
         end
         rat_side_ff <= side_out;
         sq_s2_ff    <= S2_W'(rnd_f(wide_type'(rat_r2_ff) * wide_type'(rat_side_ff.omc)));
         sq_wgt_ff   <= sq_wgt_in;
         sq_rc_ff    <= rat_rc_ff;
         sq_side_ff  <= rat_side_ff;
      end
   end

   always_comb begin
      wsum = wide_type'(rat_r0_ff)
             + rnd_f((ONE_W - wide_type'(rat_r0_ff)) * wide_type'(rat_side_ff.x5));
      if (wsum > ONE_W) begin
         sq_wgt_in = ONE_WGT;
      end else if (wsum < 0) begin
         sq_wgt_in = '0;
      end else begin
         sq_wgt_in = WGT_W'(wsum);
      end
   end

   always_comb begin
      if (wide_type'(sq_s2_ff) < ONE_W) begin
         sq_v = SQ_W'((ONE_W - wide_type'(sq_s2_ff)) <<< FRAC);
      end else begin
         sq_v = '0;
      end
      side2_in.eq  = sq_side_ff.eq;
      side2_in.zb  = (wide_type'(sq_s2_ff) >= ONE_W);
      side2_in.tir = !sq_side_ff.eq && (wide_type'(sq_s2_ff) > ONE_W);
      if (sq_side_ff.eq) begin
         side2_in.wgt = '0;
      end else if (side2_in.tir) begin
         side2_in.wgt = ONE_WGT;
      end else begin
         side2_in.wgt = sq_wgt_ff;
      end
      side2_in.rc  = sq_rc_ff;
      side2_in.rd  = {sq_rd_ff[2], sq_rd_ff[1], sq_rd_ff[0]};
      side2_in.dv  = sq_side_ff.dv;
      side2_in.nv  = sq_side_ff.nv;
      side2_in.mir = sq_side_ff.mir;
   end

   frr_sqrt u_sqrt (
      .clock  (clock),
      .enable (adv),
      .value  (sq_v),
      .root   (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= side2_in;
         for (int s = 1; s < SIDE2_DLY; s++) begin
            side2_ff[s] <= side2_ff[s-1];
         end
      end
   end

   assign side2_out = side2_ff[SIDE2_DLY-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         k_ff       <= K_W'(wide_type'(side2_out.rc) - wide_type'(root));
         k_side_ff  <= side2_out;
         kn_side_ff <= k_side_ff;
         for (int i = 0; i < 3; i++) begin
            kn_ff[i] <= KN_W'(rnd_f(wide_type'(k_ff) * wide_type'(k_side_ff.nv[i])));
            out_mir_ff[i] <= kn_side_ff.mir[i];
            if (kn_side_ff.eq) begin
               out_bent_ff[i] <= kn_side_ff.dv[i];
            end else if (kn_side_ff.zb) begin
               out_bent_ff[i] <= '0;
            end else begin
               out_bent_ff[i] <= sat_vec(wide_type'(kn_side_ff.rd[i]) + wide_type'(kn_ff[i]));
            end
         end
         out_wgt_ff  <= kn_side_ff.wgt;
         out_pass_ff <= ONE_WGT - kn_side_ff.wgt;
         out_tir_ff  <= kn_side_ff.tir;
      end
   end

   assign rsp_mirror_x        = out_mir_ff[0];
   assign rsp_mirror_y        = out_mir_ff[1];
   assign rsp_mirror_z        = out_mir_ff[2];
   assign rsp_bent_x          = out_bent_ff[0];
   assign rsp_bent_y          = out_bent_ff[1];
   assign rsp_bent_z          = out_bent_ff[2];
   assign rsp_mirror_weight   = out_wgt_ff;
   assign rsp_pass_weight     = out_pass_ff;
   assign rsp_full_reflection = out_tir_ff;

   a_full_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reflection |-> rsp_mirror_weight == ONE_WGT)
      else $error("Full reflection without a full mirror weight.");

   a_full_bent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reflection |->
         rsp_bent_x == '0 && rsp_bent_y == '0 && rsp_bent_z == '0)
      else $error("Full reflection with a non-zero refracted direction.");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> WSUM_W'(rsp_mirror_weight) + WSUM_W'(rsp_pass_weight)
                    == WSUM_W'(ONE_WGT))
      else $error("Mirror and pass weights do not add up to one.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("Pipeline moved while a result was held.");

endmodule

`default_nettype wire

>>> bench/tb_fresnel_reflect_refract.sv
// ----------------------------------------------------------------------------
// Testbench for the Fresnel reflect/refract unit.
// Directed and random ray hits are driven in bursts while the result side
// stalls on its own pattern; every result is checked against a fixed-point
// model of the mirror and Snell directions and the Schlick weight.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fresnel_reflect_refract;
   import frr_pkg::*;

   typedef struct {
      logic signed [VEC_W-1:0] d [3];
      logic signed [VEC_W-1:0] n [3];
      logic [IOR_W-1:0]        n1;
      logic [IOR_W-1:0]        n2;
   } hit_rec;

   typedef struct {
      logic signed [VEC_W-1:0] mir [3];
      logic signed [VEC_W-1:0] bent [3];
      logic [WGT_W-1:0]        wgt;
      logic [WGT_W-1:0]        pass;
      logic                    tir;
   } shade_rec;

   localparam longint ONE_Q = 64'sd1 << FRAC;
   localparam longint VMAX = (64'sd1 <<< (VEC_W - 1)) - 1;
   localparam longint VMIN = -(64'sd1 <<< (VEC_W - 1));
   localparam int     LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vec_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   vec_type req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   ior_type req_ior_in = '0, req_ior_out = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vec_type rsp_mirror_x, rsp_mirror_y, rsp_mirror_z;
   vec_type rsp_bent_x, rsp_bent_y, rsp_bent_z;
   wgt_type rsp_mirror_weight, rsp_pass_weight;
   logic rsp_full_reflection;

   hit_rec   pending_hits [$];
   shade_rec expected_shades [$];
   int  errors = 0;
   int  checked = 0;
   int  tir_seen = 0;
   int  cycles = 0;
   bit  feed_done = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   bit  hold_done = 0;

   fresnel_reflect_refract dut (.*);

   always #5 clock = ~clock;

   function automatic longint round_q(longint v);
      longint h;
      h = 64'sd1 << (FRAC - 1);
      if (v >= 0) return (v + h) >>> FRAC;
      return -((-v + h) >>> FRAC);
   endfunction

   function automatic longint clamp_vec(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint floor_root(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
      return r;
   endfunction

   function automatic shade_rec shade_hit(hit_rec h);
      shade_rec s;
      longint d [3], n [3];
      longint n1, n2, dt, c, w, ratio, r2, c2, s2, df, sm, q, r0, x, x2, x4, x5, rt, k;
      s.tir = 1'b0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(h.d[i]);
         n[i] = longint'(h.n[i]);
      end
      n1 = longint'(h.n1);
      n2 = longint'(h.n2);
      if (n1 < ONE_Q) n1 = ONE_Q;
      if (n2 < ONE_Q) n2 = ONE_Q;
      dt = round_q(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
      for (int i = 0; i < 3; i++)
         s.mir[i] = VEC_W'(clamp_vec(d[i] - round_q(2 * dt * n[i])));
      c = -dt;
      if (c > ONE_Q) c = ONE_Q;
      if (c < -ONE_Q) c = -ONE_Q;
      if (n1 == n2) begin
         w = 0;
         for (int i = 0; i < 3; i++) s.bent[i] = VEC_W'(d[i]);
      end else begin
         ratio = ((n1 << FRAC) + n2 / 2) / n2;
         r2 = round_q(ratio * ratio);
         c2 = round_q(c * c);
         s2 = round_q(r2 * (ONE_Q - c2));
         if (s2 > ONE_Q) begin
            s.tir = 1'b1;
            w = ONE_Q;
         end else begin
            df = (n1 > n2) ? n1 - n2 : n2 - n1;
            sm = n1 + n2;
            q = ((df << FRAC) + sm / 2) / sm;
            r0 = round_q(q * q);
            x = ONE_Q - c;
            x2 = round_q(x * x);
            x4 = round_q(x2 * x2);
            x5 = round_q(x4 * x);
            w = r0 + round_q((ONE_Q - r0) * x5);
            if (w > ONE_Q) w = ONE_Q;
            if (w < 0) w = 0;
         end
         if (s2 >= ONE_Q) begin
            for (int i = 0; i < 3; i++) s.bent[i] = '0;
         end else begin
            rt = floor_root((ONE_Q - s2) << FRAC);
            k = round_q(ratio * c) - rt;
            for (int i = 0; i < 3; i++)
               s.bent[i] = VEC_W'(clamp_vec(round_q(ratio * d[i]) + round_q(k * n[i])));
         end
      end
      s.wgt = WGT_W'(w);
      s.pass = WGT_W'(ONE_Q - w);
      return s;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on result %0d, %s: got %0d, expected %0d", checked, field, got, want);
      errors++;
   endtask

   function automatic hit_rec make_hit(longint dx, longint dy, longint dz, longint nx,
                                       longint ny, longint nz, longint a, longint b);
      hit_rec h;
      h.d[0] = VEC_W'(dx); h.d[1] = VEC_W'(dy); h.d[2] = VEC_W'(dz);
      h.n[0] = VEC_W'(nx); h.n[1] = VEC_W'(ny); h.n[2] = VEC_W'(nz);
      h.n1 = IOR_W'(a);
      h.n2 = IOR_W'(b);
      return h;
   endfunction

   task automatic add_hit(hit_rec h);
      pending_hits.insert(pending_hits.size(), h);
   endtask

   function automatic longint rand_ior();
      case ($urandom_range(0, 9))
         0: return longint'($urandom_range(0, 65535));
         1: return longint'($urandom_range(0, 524287));
         2: return 65536;
         default: return longint'($urandom_range(65536, 196608));
      endcase
   endfunction

   function automatic hit_rec rand_hit();
      hit_rec h;
      real ax, ay, az, bx, by, bz, la, lb;
      longint a, b;
      if ($urandom_range(0, 7) == 0) begin
         for (int i = 0; i < 3; i++) begin
            h.d[i] = VEC_W'($urandom);
            h.n[i] = VEC_W'($urandom);
         end
         h.n1 = IOR_W'($urandom);
         h.n2 = IOR_W'($urandom);
         return h;
      end
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0;
      bx = $urandom_range(0, 2000) - 1000.0;
      by = $urandom_range(0, 2000) - 1000.0;
      bz = $urandom_range(0, 2000) - 1000.0;
      la = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-6;
      lb = $sqrt(bx * bx + by * by + bz * bz) + 1.0e-6;
      if (ax * bx + ay * by + az * bz > 0.0) begin
         bx = -bx; by = -by; bz = -bz;
      end
      a = rand_ior();
      b = ($urandom_range(0, 5) == 0) ? a : rand_ior();
      h = make_hit($rtoi(ax / la * 65536.0), $rtoi(ay / la * 65536.0),
                   $rtoi(az / la * 65536.0), $rtoi(bx / lb * 65536.0),
                   $rtoi(by / lb * 65536.0), $rtoi(bz / lb * 65536.0), a, b);
      return h;
   endfunction

   initial begin
      // Normal incidence, grazing incidence, equal indices, exact and past the
      // critical angle, indices below one and the field extremes.
      add_hit(make_hit(0, 0, -65536, 0, 0, 65536, 65536, 98304));
      add_hit(make_hit(0, 0, -65536, 0, 0, 65536, 98304, 65536));
      add_hit(make_hit(65536, 0, 0, 0, 0, 65536, 98304, 65536));
      add_hit(make_hit(46341, 0, -46341, 0, 0, 65536, 80000, 80000));
      add_hit(make_hit(46341, 0, -46341, 0, 0, 65536, 131072, 65536));
      add_hit(make_hit(46341, 0, -46341, 0, 0, 65536, 92682, 65536));
      add_hit(make_hit(46341, 0, -46341, 0, 0, 65536, 92681, 65536));
      add_hit(make_hit(46341, 0, -46341, 0, 0, 65536, 92683, 65536));
      add_hit(make_hit(0, 0, -65536, 0, 0, 65536, 0, 0));
      add_hit(make_hit(0, 0, -65536, 0, 0, 65536, 1000, 524287));
      add_hit(make_hit(0, 0, -65536, 0, 0, 65536, 524287, 0));
      add_hit(make_hit(131071, 131071, 131071, 131071, 131071, 131071, 524287, 65536));
      add_hit(make_hit(-131072, -131072, -131072, -131072, -131072, -131072,
                       65536, 524287));
      add_hit(make_hit(-131072, 131071, -131072, 131071, -131072, 131071,
                       70000, 300000));
      add_hit(make_hit(0, 0, 0, 0, 0, 0, 200000, 100000));
      add_hit(make_hit(0, 0, 65536, 0, 0, 65536, 65536, 131072));
      for (int i = 0; i < 1350; i++) add_hit(rand_hit());
      feed_done = 1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 6) reset <= 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_shades.insert(expected_shades.size(), shade_hit(make_hit(
               longint'(req_dir_x), longint'(req_dir_y), longint'(req_dir_z),
               longint'(req_norm_x), longint'(req_norm_y), longint'(req_norm_z),
               longint'(req_ior_in), longint'(req_ior_out))));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_hits.size() > 0) begin
               hit_rec h;
               h = pending_hits.pop_front();
               req_valid <= 1'b1;
               req_dir_x <= h.d[0];
               req_dir_y <= h.d[1];
               req_dir_z <= h.d[2];
               req_norm_x <= h.n[0];
               req_norm_y <= h.n[1];
               req_norm_z <= h.n[2];
               req_ior_in <= h.n1;
               req_ior_out <= h.n2;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && cycles > 300 && !hold_done) begin
         hold_done <= 1;
         hold_left <= 150;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (!reset) begin
         rsp_stall <= ((cycles / 200) % 3 == 1) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_shades.size() == 0) begin
            report_mismatch("unexpected transfer", longint'(checked + 1), longint'(checked));
         end else begin
            shade_rec e;
            e = expected_shades.pop_front();
            if (rsp_mirror_x !== e.mir[0])
               report_mismatch("mirror_x", longint'(rsp_mirror_x), longint'(e.mir[0]));
            if (rsp_mirror_y !== e.mir[1])
               report_mismatch("mirror_y", longint'(rsp_mirror_y), longint'(e.mir[1]));
            if (rsp_mirror_z !== e.mir[2])
               report_mismatch("mirror_z", longint'(rsp_mirror_z), longint'(e.mir[2]));
            if (rsp_bent_x !== e.bent[0])
               report_mismatch("bent_x", longint'(rsp_bent_x), longint'(e.bent[0]));
            if (rsp_bent_y !== e.bent[1])
               report_mismatch("bent_y", longint'(rsp_bent_y), longint'(e.bent[1]));
            if (rsp_bent_z !== e.bent[2])
               report_mismatch("bent_z", longint'(rsp_bent_z), longint'(e.bent[2]));
            if (rsp_mirror_weight !== e.wgt)
               report_mismatch("mirror_weight", longint'(rsp_mirror_weight), longint'(e.wgt));
            if (rsp_pass_weight !== e.pass)
               report_mismatch("pass_weight", longint'(rsp_pass_weight), longint'(e.pass));
            if (rsp_full_reflection !== e.tir)
               report_mismatch("full_reflection", longint'(rsp_full_reflection),
                               longint'(e.tir));
            if (e.tir) tir_seen++;
            checked++;
         end
      end
   end

   initial begin
      wait (feed_done);
      while (!(pending_hits.size() == 0 && !req_valid && expected_shades.size() == 0)
             && cycles < LIMIT)
         @(posedge clock);
      if (cycles >= LIMIT) begin
         $display("fresnel_reflect_refract test failed");
         $finish;
      end else begin
         repeat (LATENCY + 20) @(posedge clock);
         $display("Checked %0d ray hits, %0d with total internal reflection, %0d errors.",
                  checked, tir_seen, errors);
         if (errors == 0 && expected_shades.size() == 0)
            $display("fresnel_reflect_refract test passed");
         else
            $display("fresnel_reflect_refract test failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
